FILE: rtl/core/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Types and constants shared by the parser, its status decoder and its checker.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    // Event kinds reported on the result channel.
    localparam logic [2:0] EV_MESSAGE      = 3'd0;
    localparam logic [2:0] EV_START        = 3'd1;
    localparam logic [2:0] EV_CONTINUE     = 3'd2;
    localparam logic [2:0] EV_STOP         = 3'd3;
    localparam logic [2:0] EV_ACTIVE_SENSE = 3'd4;

    // Message type codes.
    localparam logic [3:0] MT_NOTE_OFF      = 4'd0;
    localparam logic [3:0] MT_NOTE_ON       = 4'd1;
    localparam logic [3:0] MT_QUARTER_FRAME = 4'd7;
    localparam logic [3:0] MT_SONG_POSITION = 4'd8;
    localparam logic [3:0] MT_SONG_SELECT   = 4'd9;

    // Real-time bytes that are reported.
    localparam logic [7:0] RT_START        = 8'hFA;
    localparam logic [7:0] RT_CONTINUE     = 8'hFB;
    localparam logic [7:0] RT_STOP         = 8'hFC;
    localparam logic [7:0] RT_ACTIVE_SENSE = 8'hFE;

    // System common status bytes that are parsed.
    localparam logic [7:0] ST_QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] ST_SONG_POSITION = 8'hF2;
    localparam logic [7:0] ST_SONG_SELECT   = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQUEST  = 8'hF6;

    // Parse phase.
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DATA_A = 2'd1,
        PH_DATA_B = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    // What a status byte asks of the parser.
    typedef struct packed {
        logic       skip;   // unknown status or sysex: skip data bytes
        logic [1:0] need;   // data bytes that follow (0 to 2)
        logic [3:0] mtype;  // message type
    } t_status_info;

    // One result item.
    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] status_value;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [1:0] byte_count;
        logic [3:0] message_type;
        logic       used_running_status;
    } t_event;

endpackage

FILE: rtl/core/mbsp_in_if.sv
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel that carries one received MIDI byte per transfer.
// ----------------------------------------------------------------------------
interface mbsp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

FILE: rtl/core/mbsp_out_if.sv
// ----------------------------------------------------------------------------
// MIDI event channel
// Valid/ready channel that carries one parsed MIDI event per transfer.
// ----------------------------------------------------------------------------
interface mbsp_out_if;

    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] status_value;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [1:0] byte_count;
    logic [3:0] message_type;
    logic       used_running_status;

    modport source (
        output valid, output event_kind, output status_value, output data_first,
        output data_second, output byte_count, output message_type,
        output used_running_status, input ready
    );
    modport sink (
        input valid, input event_kind, input status_value, input data_first,
        input data_second, input byte_count, input message_type,
        input used_running_status, output ready
    );

endinterface

FILE: rtl/core/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Each byte passes from the input register through the parse step, and its
// result is loaded into the result register once that register is free.
// The parser takes one byte per cycle while the result register is free.
// Reset (synchronous, active low) empties both registers, sets the parser to
// wait for a status byte with no status held, and enables parsing.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser import mbsp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    mbsp_in_if.sink      i_rx,
    mbsp_out_if.source   o_ev
);

    // The design is a two-register pipeline. The input register holds one
    // received byte. In the cycle that byte leaves the input register, the
    // parse state is updated and, where the byte completes a message or is a
    // reported real-time byte, the result register is loaded. The result
    // register may hold a finished event while the next byte is transferred
    // in, so both sides keep moving as long as the consumer keeps up.

    // Configuration.
    logic         r_parse_enable;

    // Input register.
    logic         r_in_valid;
    logic [7:0]   r_in_byte;

    // Parse state.
    t_phase       r_phase,        n_phase;
    logic [7:0]   r_held_status,  n_held_status;
    logic [6:0]   r_held_first,   n_held_first;
    logic [3:0]   r_held_type,    n_held_type;
    logic [1:0]   r_held_count,   n_held_count;
    logic         r_held_running, n_held_running;

    // Result register.
    logic         r_out_valid;
    t_event       r_out,          n_out;
    logic         n_out_load;

    logic         w_out_free;
    logic         w_go;
    logic         w_realtime;
    logic         w_is_status;
    logic         w_parse;
    logic [7:0]   w_dec_in;
    t_status_info w_dec;

    // The result register can take a new event when it is empty or its event
    // is being transferred out in this cycle.
    assign w_out_free = !r_out_valid || o_ev.ready;
    assign w_go       = r_in_valid && w_out_free;

    assign i_rx.ready = !r_in_valid || w_out_free;

    // Bytes F8 to FF are real-time bytes and never touch the parse state.
    assign w_realtime  = (r_in_byte[7:3] == 5'b11111);
    assign w_is_status = r_in_byte[7];
    assign w_parse     = w_go && !w_realtime && r_parse_enable;

    // A status byte is decoded directly; a data byte arriving while waiting
    // for status reuses the held status byte (running status).
    assign w_dec_in = w_is_status ? r_in_byte : r_held_status;

    mbsp_status_decode u_decode (
        .i_status (w_dec_in),
        .o_info   (w_dec)
    );

    // Next parse state.
    always_comb begin
        n_phase        = r_phase;
        n_held_status  = r_held_status;
        n_held_first   = r_held_first;
        n_held_type    = r_held_type;
        n_held_count   = r_held_count;
        n_held_running = r_held_running;
        if (w_parse) begin
            if (w_is_status) begin
                // A new status byte always starts over, dropping any partly
                // received message.
                n_held_status  = r_in_byte;
                n_held_running = 1'b0;
                if (w_dec.skip) begin
                    n_phase = PH_SKIP;
                end else if (w_dec.need == 2'd0) begin
                    n_phase = PH_STATUS;
                end else begin
                    n_held_type  = w_dec.mtype;
                    n_held_count = 2'd1;
                    n_phase      = (w_dec.need == 2'd2) ? PH_DATA_A : PH_DATA_B;
                end
            end else begin
                case (r_phase)
                    PH_STATUS: begin
                        // Running status: the data byte starts a new message
                        // under the held status, if there is one to use.
                        if (r_held_status != 8'h00) begin
                            if (w_dec.skip) begin
                                n_phase = PH_SKIP;
                            end else if (w_dec.need != 2'd0) begin
                                n_held_type    = w_dec.mtype;
                                n_held_running = 1'b1;
                                if (w_dec.need == 2'd2) begin
                                    n_held_first = r_in_byte[6:0];
                                    n_held_count = 2'd2;
                                    n_phase      = PH_DATA_B;
                                end else begin
                                    n_held_count = 2'd1;
                                    n_phase      = PH_STATUS;
                                end
                            end
                        end
                    end
                    PH_DATA_A: begin
                        n_held_first = r_in_byte[6:0];
                        n_held_count = 2'd2;
                        n_phase      = PH_DATA_B;
                    end
                    PH_DATA_B: begin
                        n_phase = PH_STATUS;
                    end
                    PH_SKIP: begin
                        n_phase = PH_SKIP;
                    end
                    default: begin
                        n_phase = PH_STATUS;
                    end
                endcase
            end
        end
    end

    // Result of the byte in the input register.
    always_comb begin
        logic       v_complete;
        logic [1:0] v_count;
        logic [3:0] v_type;
        logic       v_running;

        n_out      = '0;
        n_out_load = 1'b0;

        // A data byte completes a message in the last-data phase, or while
        // waiting for status when the held status needs just one data byte.
        v_complete = !w_is_status &&
                     ((r_phase == PH_DATA_B) ||
                      ((r_phase == PH_STATUS) && (r_held_status != 8'h00) &&
                       !w_dec.skip && (w_dec.need == 2'd1)));
        v_count    = (r_phase == PH_DATA_B) ? r_held_count : 2'd1;
        v_type     = (r_phase == PH_DATA_B) ? r_held_type : w_dec.mtype;
        v_running  = (r_phase == PH_DATA_B) ? r_held_running : 1'b1;

        if (w_realtime) begin
            n_out.status_value = r_in_byte;
            n_out.byte_count   = 2'd1;
            n_out_load         = 1'b1;
            case (r_in_byte)
                RT_START:        n_out.event_kind = EV_START;
                RT_CONTINUE:     n_out.event_kind = EV_CONTINUE;
                RT_STOP:         n_out.event_kind = EV_STOP;
                RT_ACTIVE_SENSE: n_out.event_kind = EV_ACTIVE_SENSE;
                default: begin
                    // Clock, undefined real-time bytes and reset are ignored.
                    n_out.event_kind = EV_MESSAGE;
                    n_out_load       = 1'b0;
                end
            endcase
        end else if (r_parse_enable && v_complete) begin
            n_out_load                = 1'b1;
            n_out.event_kind          = EV_MESSAGE;
            n_out.status_value        = r_held_status;
            n_out.used_running_status = v_running;
            if (v_count == 2'd2) begin
                n_out.data_first  = r_held_first;
                n_out.data_second = r_in_byte[6:0];
                n_out.byte_count  = 2'd3;
            end else begin
                n_out.data_first  = r_in_byte[6:0];
                n_out.data_second = 7'd0;
                n_out.byte_count  = 2'd2;
            end
            // A note-on with zero velocity is reported as a note-off.
            if ((v_type == MT_NOTE_ON) && (v_count == 2'd2) &&
                (r_in_byte[6:0] == 7'd0)) begin
                n_out.message_type = MT_NOTE_OFF;
            end else begin
                n_out.message_type = v_type;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_enable <= 1'b1;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_STATUS;
            r_held_status  <= 8'h00;
            r_held_first   <= 7'd0;
            r_held_type    <= MT_NOTE_OFF;
            r_held_count   <= 2'd0;
            r_held_running <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_parse_enable <= i_cfg_wr_data;
            end
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= n_out_load;
            end else if (o_ev.ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase        <= n_phase;
            r_held_status  <= n_held_status;
            r_held_first   <= n_held_first;
            r_held_type    <= n_held_type;
            r_held_count   <= n_held_count;
            r_held_running <= n_held_running;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_go && n_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_ev.valid               = r_out_valid;
    assign o_ev.event_kind          = r_out.event_kind;
    assign o_ev.status_value        = r_out.status_value;
    assign o_ev.data_first          = r_out.data_first;
    assign o_ev.data_second         = r_out.data_second;
    assign o_ev.byte_count          = r_out.byte_count;
    assign o_ev.message_type        = r_out.message_type;
    assign o_ev.used_running_status = r_out.used_running_status;

endmodule

FILE: rtl/core/mbsp_status_decode.sv
// ----------------------------------------------------------------------------
// MIDI status decoder
// Maps a status byte to its message type and the number of data bytes.
// ----------------------------------------------------------------------------
module mbsp_status_decode import mbsp_pkg::*; (
    input  logic [7:0]   i_status,
    output t_status_info o_info
);

    always_comb begin
        o_info = '{skip: 1'b1, need: 2'd0, mtype: MT_NOTE_OFF};
        if (i_status[7] && (i_status[6:4] != 3'b111)) begin
            // Channel voice: program and pressure carry one data byte.
            o_info.skip  = 1'b0;
            o_info.mtype = {1'b0, i_status[6:4]};
            o_info.need  = ((i_status[6:4] == 3'd4) || (i_status[6:4] == 3'd5))
                           ? 2'd1 : 2'd2;
        end else begin
            case (i_status)
                ST_QUARTER_FRAME: begin
                    o_info = '{skip: 1'b0, need: 2'd1, mtype: MT_QUARTER_FRAME};
                end
                ST_SONG_POSITION: begin
                    o_info = '{skip: 1'b0, need: 2'd2, mtype: MT_SONG_POSITION};
                end
                ST_SONG_SELECT: begin
                    o_info = '{skip: 1'b0, need: 2'd1, mtype: MT_SONG_SELECT};
                end
                ST_TUNE_REQUEST: begin
                    o_info = '{skip: 1'b0, need: 2'd0, mtype: MT_NOTE_OFF};
                end
                default: begin
                    o_info = '{skip: 1'b1, need: 2'd0, mtype: MT_NOTE_OFF};
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/mbsp_checker.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser checker
// Assertions on the parser's ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mbsp_checker import mbsp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_event_kind,
    input logic [7:0] i_status_value,
    input logic [6:0] i_data_first,
    input logic [6:0] i_data_second,
    input logic [1:0] i_byte_count,
    input logic       i_used_running_status
);

    // A reset leaves no event pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("event valid after reset");

    // A stalled event is not withdrawn.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("event withdrawn while stalled");

    // Real-time events are single bytes with no data and no running status.
    a_realtime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_kind != EV_MESSAGE) |->
            (i_byte_count == 2'd1) && (i_data_first == 7'd0) &&
            (i_data_second == 7'd0) && !i_used_running_status &&
            (i_status_value[7:3] == 5'b11111))
        else $error("malformed real-time event");

    // Messages carry a status byte below the real-time range and one or two
    // data bytes.
    a_message_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_kind == EV_MESSAGE) |->
            i_status_value[7] && (i_status_value[7:3] != 5'b11111) &&
            ((i_byte_count == 2'd2) || (i_byte_count == 2'd3)))
        else $error("malformed message event");

    // A message with one data byte has an empty second data field.
    a_short_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_kind == EV_MESSAGE) && (i_byte_count == 2'd2) |->
            (i_data_second == 7'd0))
        else $error("second data byte on a short message");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_valid               (o_ev.valid),
    .i_ready               (o_ev.ready),
    .i_event_kind          (o_ev.event_kind),
    .i_status_value        (o_ev.status_value),
    .i_data_first          (o_ev.data_first),
    .i_data_second         (o_ev.data_second),
    .i_byte_count          (o_ev.byte_count),
    .i_used_running_status (o_ev.used_running_status)
);
